// ===== sv/hvt_pkg.sv =====
// shared types and constants of the homogeneous vertex transform unit
package hvt_pkg;

   localparam int NumRegs   = 8;
   localparam int IndexBits = 4;
   localparam int FixBits   = 32;
   localparam int FracBits  = 16;
   localparam int ProdBits  = 2 * FixBits;
   localparam int PairBits  = ProdBits + 1;
   localparam int SumBits   = ProdBits + 2;
   localparam int Latency   = 5;

   localparam logic [ProdBits-1:0] CoefOne = ProdBits'(64'h0000_0000_0001_0000);

   typedef logic signed [FixBits-1:0] fix_type;
   typedef fix_type [3:0] vec_type;
   typedef vec_type [3:0] matrix_type;

   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
      logic               in_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               out_saturated;
      logic               out_last;
   } rsp_type;

   typedef struct packed {
      fix_type value;
      logic    saturated;
   } row_result_type;

   function automatic logic [ProdBits-1:0] reset_value(input logic [IndexBits-1:0] index);
      logic [ProdBits-1:0] value;
      value = '0;
      case (index)
         4'd0: value = CoefOne;
         4'd2: value = CoefOne << FixBits;
         4'd5: value = CoefOne;
         4'd7: value = CoefOne << FixBits;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/hvt_csr.sv =====
// matrix coefficient registers written through the configuration channel
module hvt_csr
   import hvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IndexBits-1:0] csr_index,
   input  logic [ProdBits-1:0]  csr_data,
   output matrix_type           matrix
);

   logic [NumRegs-1:0][ProdBits-1:0] regs_ff;
   logic [NumRegs-1:0][ProdBits-1:0] regs_in;

   assign csr_ready = 1'b1;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid && csr_ready && (csr_index < IndexBits'(NumRegs))) begin
         regs_in[csr_index[2:0]] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            regs_ff[i] <= reset_value(IndexBits'(i));
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         matrix[r][0] = regs_ff[2*r][FixBits-1:0];
         matrix[r][1] = regs_ff[2*r][ProdBits-1:FixBits];
         matrix[r][2] = regs_ff[2*r+1][FixBits-1:0];
         matrix[r][3] = regs_ff[2*r+1][ProdBits-1:FixBits];
      end
   end

endmodule

// ===== sv/hvt_row.sv =====
// pipelined dot product of one matrix row with the point, rounded and saturated
module hvt_row
   import hvt_pkg::*;
(
   input  logic           clock,
   input  vec_type        point,
   input  vec_type        coef,
   output row_result_type result
);

   localparam logic signed [PairBits-1:0] RoundHalf = PairBits'(1) <<< (FracBits - 1);

   logic signed [3:0][ProdBits-1:0] prod_ff;
   logic signed [3:0][ProdBits-1:0] prod_in;
   logic signed [1:0][PairBits-1:0] pair_ff;
   logic signed [1:0][PairBits-1:0] pair_in;
   logic signed [SumBits-1:0]       sum_ff;
   logic signed [SumBits-1:0]       sum_in;
   row_result_type                  result_ff;
   row_result_type                  result_in;
   logic [SumBits-FixBits-FracBits:0] top_bits;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         prod_in[c] = ProdBits'(signed'(coef[c])) * ProdBits'(signed'(point[c]));
      end
      pair_in[0] = PairBits'(signed'(prod_ff[0])) + PairBits'(signed'(prod_ff[1])) + RoundHalf;
      pair_in[1] = PairBits'(signed'(prod_ff[2])) + PairBits'(signed'(prod_ff[3]));
      sum_in     = SumBits'(signed'(pair_ff[0])) + SumBits'(signed'(pair_ff[1]));
   end

   assign top_bits = sum_ff[SumBits-1:FixBits+FracBits-1];

   always_comb begin
      result_in.saturated = !((&top_bits) || !(|top_bits));
      if (!result_in.saturated) begin
         result_in.value = sum_ff[FixBits+FracBits-1:FracBits];
      end else if (sum_ff[SumBits-1]) begin
         result_in.value = {1'b1, {(FixBits-1){1'b0}}};
      end else begin
         result_in.value = {1'b0, {(FixBits-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== sv/homogeneous_vertex_transform_unit.sv =====
// top level of the homogeneous vertex transform unit
//
// transforms one homogeneous point (x, y, z, w) per transaction by a 4x4
// signed q16.16 matrix; each output component is one row dot the point,
// summed exactly, rounded to nearest (ties up) and saturated to 32 bits
// req channel: a transaction is taken at a clock edge with start high and
// busy low; busy stays low, so a new point may enter every cycle
// rsp channel: rsp_valid marks each result for exactly one cycle
// the accepted point is registered and then passes the product, pair, sum
// and result registers; throughput is one point per clock, set by the fully
// pipelined multiply, pair add, row add and saturate stages of four row units
// csr channel: csr_ready is always high; index 0..7 selects one 64-bit
// register holding two coefficients, other indexes are ignored; write only
// while no transaction is in flight
// reset (synchronous) loads the identity matrix and clears all valid bits;
// the receiver cannot stall, so results are never held back
module homogeneous_vertex_transform_unit
   import hvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IndexBits-1:0] csr_index,
   input  logic [ProdBits-1:0]  csr_data
);

   matrix_type              matrix;
   vec_type                 point_ff;
   vec_type                 point_in;
   logic [Latency-1:0]      valid_ff;
   logic [Latency-1:0]      valid_in;
   logic [Latency-1:0]      last_ff;
   logic [Latency-1:0]      last_in;
   row_result_type [3:0]    row_result;
   logic                    accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .matrix    (matrix)
   );

   always_comb begin
      point_in[0] = req_data.in_x;
      point_in[1] = req_data.in_y;
      point_in[2] = req_data.in_z;
      point_in[3] = req_data.in_w;
      valid_in    = {valid_ff[Latency-2:0], accept};
      last_in     = {last_ff[Latency-2:0], req_data.in_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      last_ff  <= last_in;
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      hvt_row u_row (
         .clock  (clock),
         .point  (point_ff),
         .coef   (matrix[r]),
         .result (row_result[r])
      );
   end

   assign rsp_valid = valid_ff[Latency-1];

   always_comb begin
      rsp_data.out_x         = row_result[0].value;
      rsp_data.out_y         = row_result[1].value;
      rsp_data.out_z         = row_result[2].value;
      rsp_data.out_w         = row_result[3].value;
      rsp_data.out_saturated = row_result[0].saturated || row_result[1].saturated ||
                               row_result[2].saturated || row_result[3].saturated;
      rsp_data.out_last      = last_ff[Latency-1];
   end

endmodule

// ===== tb/homogeneous_vertex_transform_unit_tb.sv =====
// testbench of the homogeneous vertex transform unit
`timescale 1ns / 1ps

module homogeneous_vertex_transform_unit_tb;
   import hvt_pkg::*;

   typedef enum logic [IndexBits-1:0] {
      RegRow0Cols01, RegRow0Cols23, RegRow1Cols01, RegRow1Cols23,
      RegRow2Cols01, RegRow2Cols23, RegRow3Cols01, RegRow3Cols23
   } reg_index_type;

   typedef enum int {ValFull, ValUnit, ValExtreme, ValMixed} value_kind_type;

   localparam fix_type FixMax  = 32'h7fff_ffff;
   localparam fix_type FixMin  = 32'h8000_0000;
   localparam fix_type FixOne  = 32'h0001_0000;
   localparam fix_type FixHalf = 32'h0000_8000;
   localparam fix_type FixLsb  = 32'h0000_0001;

   localparam logic signed [67:0] RoundHalf = 68'sd32768;
   localparam logic signed [67:0] SumMax    = 68'sd2147483647;
   localparam logic signed [67:0] SumMin    = -68'sd2147483648;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [IndexBits-1:0] csr_index = '0;
   logic [ProdBits-1:0]  csr_data = '0;

   logic [63:0] matrix_words [NumRegs] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };
   rsp_type expected_vertices [$];
   int      mismatches = 0;
   bit      no_gaps = 1'b0;

   homogeneous_vertex_transform_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type transform_vertex(input req_type pt);
      fix_type           coord [4];
      fix_type           row_out [4];
      fix_type           coef;
      logic [63:0]       word;
      logic signed [67:0] acc;
      logic signed [67:0] rounded;
      rsp_type           res;
      coord = '{pt.in_x, pt.in_y, pt.in_z, pt.in_w};
      res = '0;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int c = 0; c < 4; c++) begin
            word = matrix_words[r * 2 + c / 2];
            coef = (c % 2 == 1) ? word[63:32] : word[31:0];
            acc = acc + coef * coord[c];
         end
         rounded = (acc + RoundHalf) >>> FracBits;
         if (rounded > SumMax) begin
            row_out[r] = FixMax;
            res.out_saturated = 1'b1;
         end else if (rounded < SumMin) begin
            row_out[r] = FixMin;
            res.out_saturated = 1'b1;
         end else begin
            row_out[r] = rounded[31:0];
         end
      end
      res.out_x = row_out[0];
      res.out_y = row_out[1];
      res.out_z = row_out[2];
      res.out_w = row_out[3];
      res.out_last = pt.in_last;
      return res;
   endfunction

   function automatic fix_type make_value(input value_kind_type kind);
      fix_type v;
      case (kind)
         ValFull: v = $urandom;
         ValUnit: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         ValExtreme: begin
            case ($urandom_range(0, 6))
               0: v = FixMax;
               1: v = FixMin;
               2: v = FixOne;
               3: v = -FixOne;
               4: v = FixLsb;
               5: v = -FixLsb;
               default: v = '0;
            endcase
         end
         default: v = make_value(value_kind_type'($urandom_range(ValFull, ValExtreme)));
      endcase
      return v;
   endfunction

   function automatic req_type make_point(input fix_type x, input fix_type y, input fix_type z,
                                          input fix_type w, input logic last);
      req_type pt;
      pt.in_x = x;
      pt.in_y = y;
      pt.in_z = z;
      pt.in_w = w;
      pt.in_last = last;
      return pt;
   endfunction

   function automatic req_type random_point();
      return make_point(make_value(ValMixed), make_value(ValMixed), make_value(ValMixed),
                        make_value(ValMixed), $urandom_range(0, 7) == 0);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_vertices.pop_front();
            compare_field("out_x", want.out_x, rsp_data.out_x);
            compare_field("out_y", want.out_y, rsp_data.out_y);
            compare_field("out_z", want.out_z, rsp_data.out_z);
            compare_field("out_w", want.out_w, rsp_data.out_w);
            compare_field("out_saturated", 32'(want.out_saturated), 32'(rsp_data.out_saturated));
            compare_field("out_last", 32'(want.out_last), 32'(rsp_data.out_last));
         end
      end
   end

   task automatic send_point(input req_type pt);
      while (!no_gaps && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         req_data <= random_point();
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= pt;
      do @(posedge clock); while (busy);
      expected_vertices.push_back(transform_vertex(pt));
   endtask

   task automatic write_reg(input logic [IndexBits-1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index < NumRegs)
         matrix_words[index] = value;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_vertices.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_reset_matrix();
      send_point(make_point('0, '0, '0, '0, 1'b0));
      send_point(make_point(FixMax, FixMax, FixMax, FixMax, 1'b1));
      send_point(make_point(FixMin, FixMin, FixMin, FixMin, 1'b0));
      send_point(make_point(FixMax, FixMin, FixLsb, -FixLsb, 1'b1));
      send_point(make_point(FixOne, -FixOne, FixHalf, -FixHalf, 1'b0));
      drain();
   endtask

   task automatic test_rounding();
      write_reg(RegRow0Cols01, {FixHalf, FixHalf});
      write_reg(RegRow0Cols23, '0);
      write_reg(RegRow1Cols01, {32'h0, FixHalf});
      write_reg(RegRow1Cols23, '0);
      write_reg(RegRow2Cols01, {32'h0, -FixHalf});
      write_reg(RegRow2Cols23, '0);
      write_reg(RegRow3Cols01, {FixLsb, FixLsb});
      write_reg(RegRow3Cols23, {FixLsb, FixLsb});
      csr_valid <= 1'b0;
      send_point(make_point(FixLsb, '0, '0, '0, 1'b0));
      send_point(make_point(-FixLsb, '0, '0, '0, 1'b0));
      send_point(make_point(FixLsb, FixLsb, '0, '0, 1'b1));
      send_point(make_point(FixHalf, '0, '0, '0, 1'b0));
      send_point(make_point(32'h0000_7fff, '0, '0, '0, 1'b0));
      send_point(make_point(-FixHalf, FixLsb, -FixLsb, 32'h0000_4000, 1'b1));
      drain();
   endtask

   task automatic test_saturation();
      write_reg(RegRow0Cols01, {FixMax, FixMax});
      write_reg(RegRow0Cols23, {FixMax, FixMax});
      write_reg(RegRow1Cols01, {FixMin, FixMin});
      write_reg(RegRow1Cols23, {FixMin, FixMin});
      write_reg(RegRow2Cols01, {FixMin, FixMax});
      write_reg(RegRow2Cols23, {FixMin, FixMax});
      write_reg(RegRow3Cols01, {32'h0, FixOne});
      write_reg(RegRow3Cols23, {-FixOne, 32'h0});
      csr_valid <= 1'b0;
      send_point(make_point(FixMax, FixMax, FixMax, FixMax, 1'b0));
      send_point(make_point(FixMin, FixMin, FixMin, FixMin, 1'b1));
      send_point(make_point(FixMax, FixMin, FixMax, FixMin, 1'b0));
      send_point(make_point(FixOne, FixOne, FixOne, FixOne, 1'b0));
      send_point(make_point(FixLsb, '0, -FixLsb, '0, 1'b1));
      drain();
   endtask

   // writes outside the register file must leave the matrix alone
   task automatic test_bad_index();
      for (int i = NumRegs; i < (1 << IndexBits); i++)
         write_reg(IndexBits'(i), {$urandom, $urandom});
      csr_valid <= 1'b0;
      repeat (3) send_point(random_point());
      drain();
   endtask

   task automatic test_random_phases();
      value_kind_type kind;
      for (int p = 0; p < 6; p++) begin
         case (p)
            1: kind = ValExtreme;
            2: kind = ValUnit;
            3: kind = ValFull;
            default: kind = ValMixed;
         endcase
         for (int i = 0; i < NumRegs; i++) begin
            if ($urandom_range(0, 3) == 0)
               write_reg(IndexBits'($urandom_range(NumRegs, (1 << IndexBits) - 1)),
                         {$urandom, $urandom});
            write_reg(IndexBits'(i), {make_value(kind), make_value(kind)});
         end
         csr_valid <= 1'b0;
         no_gaps = (p == 3);
         repeat (100) send_point(random_point());
         no_gaps = 1'b0;
         drain();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_matrix();
      test_rounding();
      test_saturation();
      test_bad_index();
      test_random_phases();
      drain();
      repeat (Latency + 4) @(posedge clock);
      if (mismatches == 0 && expected_vertices.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
sv/hvt_pkg.sv
sv/hvt_csr.sv
sv/hvt_row.sv
sv/homogeneous_vertex_transform_unit.sv
tb/homogeneous_vertex_transform_unit_tb.sv
